@@ src/lse_pkg.sv @@
// Package for the LSB stego extractor: header size, decoder state and result types.
// No dependencies; lse_bit_step.sv and lsb_stego_extractor.sv use it by scoped names.
package lse_pkg;

   // Length header size in hidden bits (8 to 32).
   localparam int HEADER_BITS = 32;
   localparam int HDR_CNT_W   = $clog2(HEADER_BITS + 1);
   // Width in which the header value and the maximum length are compared.
   localparam int CMP_W       = (HEADER_BITS > 16) ? HEADER_BITS : 16;
   localparam int LEN_W       = 16;
   localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 16'd1000;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_MESSAGE = 2'd1,
      PH_DONE    = 2'd2
   } phase_type;

   typedef struct packed {
      phase_type              phase;
      logic [HEADER_BITS-1:0] header_shift;
      logic [HDR_CNT_W-1:0]   header_count;
      logic [7:0]             byte_shift;
      logic [2:0]             bit_count;
      logic [LEN_W-1:0]       message_length;
      logic [LEN_W-1:0]       bytes_done;
   } state_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] message_byte;
      logic       status;
      logic       last;
   } result_type;

   localparam state_type STATE_CLEAR = '{
      phase:          PH_HEADER,
      header_shift:   '0,
      header_count:   '0,
      byte_shift:     '0,
      bit_count:      '0,
      message_length: '0,
      bytes_done:     '0
   };

   localparam result_type RESULT_NONE = '{
      valid: 1'b0, message_byte: 8'd0, status: 1'b0, last: 1'b0
   };

endpackage

@@ src/lsb_stego_extractor.sv @@
// Top level of the LSB stego extractor: handshakes, decoder state, result register.
// Depends on lse_pkg and lse_bit_step (three chained bit steps per pixel).
//
//   channel  | ports                                         | direction
//   ---------+-----------------------------------------------+----------
//   req      | req_valid/ready, frame_start, red, green, blue | in
//   rsp      | rsp_valid/ready, message_byte, status, last    | out
//   csr      | csr_wr_en, csr_wr_data (max_length)            | in
//
// One pixel item per cycle while req_ready is high; each item yields zero or one result item in the next cycle.
// The three hidden bits of a pixel pass through three chained bit-step units in the
// same cycle, so the state register closes the loop through all three steps.
// Reset (synchronous) restores max_length to 1000 and starts the header phase.
// A full result register that is not taken stalls req_ready; otherwise a new item
// is accepted in the same cycle the held result leaves.
module lsb_stego_extractor (
   input  logic                          clock,
   input  logic                          reset,
   // pixel input
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_frame_start,
   input  logic [7:0]                    req_red,
   input  logic [7:0]                    req_green,
   input  logic [7:0]                    req_blue,
   // decoded output
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_message_byte,
   output logic                          rsp_status,
   output logic                          rsp_last,
   // configuration
   input  logic                          csr_wr_en,
   input  logic [lse_pkg::LEN_W-1:0]     csr_wr_data
);

   lse_pkg::state_type              state_ff, state_in;
   lse_pkg::state_type              state_start, state_s1, state_s2;
   lse_pkg::result_type             res0, res1, res2, res_sel;
   logic [lse_pkg::LEN_W-1:0]       max_length_ff;
   logic                            rsp_valid_ff;
   logic [7:0]                      rsp_byte_ff;
   logic                            rsp_status_ff;
   logic                            rsp_last_ff;
   logic                            accept;

   // Take a new pixel whenever the result register is empty or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Frame start restarts decoding with this pixel as the first of the frame.
   assign state_start = req_frame_start ? lse_pkg::STATE_CLEAR : state_ff;

   // Hidden bits in order red, green, blue.
   lse_bit_step u_step_red (
      .state_cur  (state_start),
      .hidden_bit (req_red[0]),
      .max_length (max_length_ff),
      .state_nxt  (state_s1),
      .result     (res0)
   );

   lse_bit_step u_step_green (
      .state_cur  (state_s1),
      .hidden_bit (req_green[0]),
      .max_length (max_length_ff),
      .state_nxt  (state_s2),
      .result     (res1)
   );

   lse_bit_step u_step_blue (
      .state_cur  (state_s2),
      .hidden_bit (req_blue[0]),
      .max_length (max_length_ff),
      .state_nxt  (state_in),
      .result     (res2)
   );

   // At most one step completes a result per pixel; pick it.
   always_comb begin
      priority if (res0.valid) begin
         res_sel = res0;
      end else if (res1.valid) begin
         res_sel = res1;
      end else begin
         res_sel = res2;
      end
   end

   // Decoder state and configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lse_pkg::STATE_CLEAR;
         max_length_ff <= lse_pkg::MAX_LENGTH_RESET;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (csr_wr_en) begin
            max_length_ff <= csr_wr_data;
         end
      end
   end

   // Result register: load on accept, drop when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= res_sel.valid;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_byte_ff   <= res_sel.message_byte;
         rsp_status_ff <= res_sel.status;
         rsp_last_ff   <= res_sel.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_message_byte = rsp_byte_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_last         = rsp_last_ff;

   // A pixel in the done phase without frame start must leave the state alone.
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      accept && !req_frame_start && (state_ff.phase == lse_pkg::PH_DONE)
      |=> $stable(state_ff))
      else $error("done phase state changed");

   // A held error or final byte means the decoder has finished the frame.
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> (state_ff.phase == lse_pkg::PH_DONE))
      else $error("last result without done phase");

   // In the message phase fewer bytes than the length have been emitted.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == lse_pkg::PH_MESSAGE)
      |-> (state_ff.bytes_done < state_ff.message_length))
      else $error("byte count reached length in message phase");

   // An error result carries a zero byte and is marked last.
   a_error_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_last && (rsp_message_byte == 8'd0))
      else $error("malformed error result");

endmodule

@@ src/lse_bit_step.sv @@
// One hidden-bit step of the extractor: advance header or message state by one bit.
// Depends on lse_pkg for the state and result types.
module lse_bit_step (
   input  lse_pkg::state_type          state_cur,
   input  logic                        hidden_bit,
   input  logic [lse_pkg::LEN_W-1:0]   max_length,
   output lse_pkg::state_type          state_nxt,
   output lse_pkg::result_type         result
);

   logic [lse_pkg::HEADER_BITS-1:0] hdr_shift;
   logic [lse_pkg::HDR_CNT_W-1:0]   hdr_count;
   logic [lse_pkg::CMP_W-1:0]       len_ext;
   logic [lse_pkg::CMP_W-1:0]       max_ext;
   logic                            len_bad;
   logic [7:0]                      byte_next;
   logic [lse_pkg::LEN_W-1:0]       done_next;

   assign hdr_shift = {state_cur.header_shift[lse_pkg::HEADER_BITS-2:0], hidden_bit};
   assign hdr_count = state_cur.header_count + lse_pkg::HDR_CNT_W'(1);
   assign len_ext   = lse_pkg::CMP_W'(hdr_shift);
   assign max_ext   = lse_pkg::CMP_W'(max_length);
   assign len_bad   = (hdr_shift == '0) || hdr_shift[lse_pkg::HEADER_BITS-1]
                      || (len_ext > max_ext);
   assign byte_next = {state_cur.byte_shift[6:0], hidden_bit};
   assign done_next = state_cur.bytes_done + lse_pkg::LEN_W'(1);

   always_comb begin
      state_nxt = state_cur;
      result    = lse_pkg::RESULT_NONE;
      unique case (state_cur.phase)
         lse_pkg::PH_HEADER: begin
            state_nxt.header_shift = hdr_shift;
            state_nxt.header_count = hdr_count;
            if (hdr_count >= lse_pkg::HDR_CNT_W'(lse_pkg::HEADER_BITS)) begin
               if (len_bad) begin
                  result.valid     = 1'b1;
                  result.status    = 1'b1;
                  result.last      = 1'b1;
                  state_nxt.phase  = lse_pkg::PH_DONE;
               end else begin
                  state_nxt.message_length = len_ext[lse_pkg::LEN_W-1:0];
                  state_nxt.bytes_done     = '0;
                  state_nxt.byte_shift     = '0;
                  state_nxt.bit_count      = '0;
                  state_nxt.phase          = lse_pkg::PH_MESSAGE;
               end
            end
         end
         lse_pkg::PH_MESSAGE: begin
            if (state_cur.bit_count == 3'd7) begin
               state_nxt.bit_count  = '0;
               state_nxt.bytes_done = done_next;
               state_nxt.byte_shift = '0;
               result.valid         = 1'b1;
               result.message_byte  = byte_next;
               if (done_next >= state_cur.message_length) begin
                  result.last     = 1'b1;
                  state_nxt.phase = lse_pkg::PH_DONE;
               end
            end else begin
               state_nxt.bit_count  = state_cur.bit_count + 3'd1;
               state_nxt.byte_shift = byte_next;
            end
         end
         default: begin
            // done phase and the unused code: ignore the bit
         end
      endcase
   end

endmodule
